// ===== hdl/ipv6_range_word_splitter_macros.svh =====
// ----------------------------------------------------------------------------
// ipv6 range word splitter assertion macros
// shared concurrent assertion forms, same-cycle and next-cycle implication
// ----------------------------------------------------------------------------
`ifndef IPV6_RANGE_WORD_SPLITTER_MACROS_SVH
`define IPV6_RANGE_WORD_SPLITTER_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define IRWS_ASSERT_NOW(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// consequent holds in the cycle after the antecedent
`define IRWS_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// ===== hdl/irws_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv6 range word splitter package
// item types, word constants and slot counts
// ----------------------------------------------------------------------------
`default_nettype none

package irws_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = 4;
    localparam int NUM_SLOTS = 7;
    localparam int SLOT_W    = 3;
    localparam int WIDX_W    = 3;

    localparam logic [WORD_W-1:0] WORD_ALL  = 32'hffff_ffff;
    localparam logic [WORD_W-1:0] WORD_ZERO = 32'h0000_0000;

    // slot numbering: min-side cuts, max-side cuts, closing range
    localparam logic [SLOT_W-1:0] SLOT_FINAL = 3'd6;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [63:0] range_min_hi;
        logic [63:0] range_min_lo;
        logic [63:0] range_max_hi;
        logic [63:0] range_max_lo;
    } range_t;

    typedef struct packed {
        logic [63:0] part_min_hi;
        logic [63:0] part_min_lo;
        logic [63:0] part_max_hi;
        logic [63:0] part_max_lo;
        logic        is_empty;
        logic        last_part;
    } part_t;

endpackage

`default_nettype wire

// ===== hdl/ipv6_range_word_splitter.sv =====
// ----------------------------------------------------------------------------
// ipv6 range word splitter
// splits one inclusive 128-bit address range into word-wise product ranges
// ----------------------------------------------------------------------------
// One range item gives 1 to 7 part items, one per clock while the part side
// does not stall. The item sits in an input register; up to seven candidate
// parts are worked out from it combinationally and issued lowest first into
// the part register. The next range item is taken in the cycle that its
// predecessor's last part is issued, and the first part of an item passes
// through the input register and then the part register.
`default_nettype none

`include "ipv6_range_word_splitter_macros.svh"

module ipv6_range_word_splitter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             range_valid,
    output logic             range_stall,
    input  irws_pkg::range_t range,
    output logic             part_valid,
    input  logic             part_stall,
    output irws_pkg::part_t  part
);

    irws_pkg::range_t range_reg;
    irws_pkg::part_t  part_reg;
    irws_pkg::part_t  part_next;
    logic             part_valid_reg;
    logic             part_valid_next;
    logic             fresh_reg;
    logic             fresh_next;
    logic [irws_pkg::NUM_SLOTS-1:0] pend_reg;
    logic [irws_pkg::NUM_SLOTS-1:0] pend_next;

    irws_pkg::word_t mn [irws_pkg::NUM_WORDS];
    irws_pkg::word_t mx [irws_pkg::NUM_WORDS];
    logic [irws_pkg::NUM_WORDS-1:0] tail_nz;
    irws_pkg::word_t cm;
    logic [irws_pkg::WIDX_W-1:0] diff_idx;
    logic [irws_pkg::WIDX_W-1:0] jmax;
    logic [1:0]                  jmin;
    logic                        jmin_ok;
    logic                        is_gt;
    logic                        is_any;

    irws_pkg::word_t cand_min [irws_pkg::NUM_SLOTS][irws_pkg::NUM_WORDS];
    irws_pkg::word_t cand_max [irws_pkg::NUM_SLOTS][irws_pkg::NUM_WORDS];
    logic [irws_pkg::NUM_SLOTS-1:0] cand_ok;

    logic [irws_pkg::NUM_SLOTS-1:0] rem;
    logic [irws_pkg::NUM_SLOTS-1:0] rem_after;
    logic [irws_pkg::SLOT_W-1:0]    pick_idx;
    logic busy;
    logic out_free;
    logic issue;
    logic done;
    logic accept;

    // word view of the held item
    always_comb
    begin
        mn[0] = range_reg.range_min_hi[63:32];
        mn[1] = range_reg.range_min_hi[31:0];
        mn[2] = range_reg.range_min_lo[63:32];
        mn[3] = range_reg.range_min_lo[31:0];
        mx[0] = range_reg.range_max_hi[63:32];
        mx[1] = range_reg.range_max_hi[31:0];
        mx[2] = range_reg.range_max_lo[63:32];
        mx[3] = range_reg.range_max_lo[31:0];
        is_gt  = {range_reg.range_min_hi, range_reg.range_min_lo} >
                 {range_reg.range_max_hi, range_reg.range_max_lo};
        is_any = ({range_reg.range_max_hi, range_reg.range_max_lo} == '0);
    end

    // split points
    always_comb
    begin
        diff_idx = 3'(irws_pkg::NUM_WORDS);
        for (int w = irws_pkg::NUM_WORDS - 1; w >= 0; w--)
        begin
            if (mn[w] != mx[w])
                diff_idx = 3'(w);
        end
        for (int w = 0; w < irws_pkg::NUM_WORDS; w++)
        begin
            tail_nz[w] = 1'b0;
            for (int v = w + 1; v < irws_pkg::NUM_WORDS; v++)
                tail_nz[w] = tail_nz[w] | (mn[v] != irws_pkg::WORD_ZERO);
        end
        // min after rounding up its tail
        cm = diff_idx[2] ? irws_pkg::WORD_ZERO
                         : mn[diff_idx[1:0]] + 32'(tail_nz[diff_idx[1:0]]);
        jmin_ok = 1'b0;
        jmin    = 2'd0;
        jmax    = diff_idx;
        for (int w = 0; w < irws_pkg::NUM_WORDS; w++)
        begin
            if (3'(w) > diff_idx && mn[w] != irws_pkg::WORD_ZERO)
            begin
                jmin_ok = 1'b1;
                jmin    = 2'(w);
            end
            if (3'(w) > diff_idx && mx[w] != irws_pkg::WORD_ALL)
                jmax = 3'(w);
        end
    end

    // candidate parts
    always_comb
    begin
        // min-side cuts, lowest word first
        for (int s = 0; s < 3; s++)
        begin
            cand_ok[s] = !is_gt && !is_any && jmin_ok && 3'(3 - s) > diff_idx &&
                         2'(3 - s) <= jmin &&
                         (2'(3 - s) == jmin || mn[3 - s] != irws_pkg::WORD_ALL);
            for (int w = 0; w < irws_pkg::NUM_WORDS; w++)
            begin
                if (w < 3 - s)
                begin
                    cand_min[s][w] = mn[w];
                    cand_max[s][w] = mn[w];
                end
                else if (w == 3 - s)
                begin
                    cand_min[s][w] = (2'(3 - s) == jmin) ? mn[w] : mn[w] + 32'd1;
                    cand_max[s][w] = irws_pkg::WORD_ALL;
                end
                else
                begin
                    cand_min[s][w] = irws_pkg::WORD_ZERO;
                    cand_max[s][w] = irws_pkg::WORD_ALL;
                end
            end
        end
        // max-side cuts, highest word first
        for (int s = 3; s < 6; s++)
        begin
            cand_ok[s] = !is_gt && !is_any && 3'(s - 3) >= diff_idx && 3'(s - 3) < jmax &&
                         mx[s - 3] != ((3'(s - 3) == diff_idx) ? cm : irws_pkg::WORD_ZERO);
            for (int w = 0; w < irws_pkg::NUM_WORDS; w++)
            begin
                if (w < s - 3)
                begin
                    cand_min[s][w] = mx[w];
                    cand_max[s][w] = mx[w];
                end
                else if (w == s - 3)
                begin
                    cand_min[s][w] = (3'(w) == diff_idx) ? cm : irws_pkg::WORD_ZERO;
                    cand_max[s][w] = mx[w] - 32'd1;
                end
                else
                begin
                    cand_min[s][w] = irws_pkg::WORD_ZERO;
                    cand_max[s][w] = irws_pkg::WORD_ALL;
                end
            end
        end
        // closing range, or the single result of the special cases
        cand_ok[6] = 1'b1;
        for (int w = 0; w < irws_pkg::NUM_WORDS; w++)
        begin
            if (is_gt)
            begin
                cand_min[6][w] = irws_pkg::WORD_ZERO;
                cand_max[6][w] = irws_pkg::WORD_ZERO;
            end
            else if (is_any)
            begin
                cand_min[6][w] = irws_pkg::WORD_ZERO;
                cand_max[6][w] = irws_pkg::WORD_ALL;
            end
            else
            begin
                if (3'(w) < jmax)
                    cand_min[6][w] = mx[w];
                else if (3'(w) == jmax)
                    cand_min[6][w] = (jmax == diff_idx) ? cm : irws_pkg::WORD_ZERO;
                else
                    cand_min[6][w] = irws_pkg::WORD_ZERO;
                cand_max[6][w] = mx[w];
            end
        end
    end

    // issue control
    always_comb
    begin
        rem      = fresh_reg ? cand_ok : pend_reg;
        pick_idx = irws_pkg::SLOT_FINAL;
        for (int s = irws_pkg::NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (rem[s])
                pick_idx = 3'(s);
        end
        rem_after = rem & ~(7'd1 << pick_idx);
        busy      = fresh_reg || (pend_reg != '0);
        out_free  = !part_valid_reg || !part_stall;
        issue     = busy && out_free;
        done      = issue && (rem_after == '0);
        range_stall = busy && !done;
        accept    = range_valid && !range_stall;

        fresh_next      = accept ? 1'b1 : (issue ? 1'b0 : fresh_reg);
        pend_next       = issue ? rem_after : pend_reg;
        part_valid_next = out_free ? issue : part_valid_reg;

        part_next.part_min_hi = {cand_min[pick_idx][0], cand_min[pick_idx][1]};
        part_next.part_min_lo = {cand_min[pick_idx][2], cand_min[pick_idx][3]};
        part_next.part_max_hi = {cand_max[pick_idx][0], cand_max[pick_idx][1]};
        part_next.part_max_lo = {cand_max[pick_idx][2], cand_max[pick_idx][3]};
        part_next.is_empty    = is_gt && (pick_idx == irws_pkg::SLOT_FINAL);
        part_next.last_part   = (rem_after == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg      <= 1'b0;
            pend_reg       <= '0;
            part_valid_reg <= 1'b0;
        end
        else
        begin
            fresh_reg      <= fresh_next;
            pend_reg       <= pend_next;
            part_valid_reg <= part_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            range_reg <= range;
        if (issue)
            part_reg <= part_next;
    end

    assign part_valid = part_valid_reg;
    assign part       = part_reg;

    `IRWS_ASSERT_NOW(a_issue_one_slot, clk, rst_n, issue, $onehot(rem ^ rem_after), "issue must retire exactly one slot")
    `IRWS_ASSERT_NOW(a_final_slot_set, clk, rst_n, fresh_reg, cand_ok[6], "closing slot missing on a new item")
    `IRWS_ASSERT_NEXT(a_accept_fresh, clk, rst_n, accept, fresh_reg, "accepted item not marked for issue")
    `IRWS_ASSERT_NEXT(a_done_last, clk, rst_n, done, part_valid_reg && part_reg.last_part, "final part not flagged last")
    `IRWS_ASSERT_NOW(a_empty_last, clk, rst_n, part_valid_reg && part_reg.is_empty, part_reg.last_part, "empty part must be the only part")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv6 range word splitter testbench
// drives range items through a valid/stall channel with random gaps and
// checks every part item against a predicted list of word-wise sub-ranges
// ----------------------------------------------------------------------------
module tb;

    import irws_pkg::*;

    typedef logic [0:NUM_WORDS-1][WORD_W-1:0] addr_t;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   range_valid;
    logic   range_stall;
    range_t range_in;
    logic   part_valid;
    logic   part_stall = 1'b0;
    part_t  part_out;

    part_t       expected_parts[$];
    part_t       want_part;
    int unsigned cycle_count = 0;
    int unsigned errors = 0;
    int unsigned ranges_sent = 0;
    int unsigned parts_checked = 0;
    int          stall_left = 0;
    bit          send_idle = 1'b1;
    bit          part_idle = 1'b1;

    ipv6_range_word_splitter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .range_valid (range_valid),
        .range_stall (range_stall),
        .range       (range_in),
        .part_valid  (part_valid),
        .part_stall  (part_stall),
        .part        (part_out)
    );

    always #5 clk = ~clk;

    function automatic void add_part(input addr_t lo, input addr_t hi, input logic empty,
                                     input logic last);
        part_t p;
        {p.part_min_hi, p.part_min_lo} = lo;
        {p.part_max_hi, p.part_max_lo} = hi;
        p.is_empty  = empty;
        p.last_part = last;
        expected_parts.push_back(p);
    endfunction

    function automatic void split_range(input range_t r);
        addr_t mn;
        addr_t mx;
        addr_t cur;
        addr_t top;
        int    i;
        int    j;
        int    t;
        mn = {r.range_min_hi, r.range_min_lo};
        mx = {r.range_max_hi, r.range_max_lo};
        if (mn > mx)
        begin
            add_part('0, '0, 1'b1, 1'b1);
            return;
        end
        if (mx == '0)
        begin
            add_part('0, '1, 1'b0, 1'b1);
            return;
        end
        cur = mn;
        i = 0;
        while (i < NUM_WORDS && mn[i] == mx[i])
            i++;
        // min side, lowest nonzero word first
        j = NUM_WORDS - 1;
        while (j > i && mn[j] == WORD_ZERO)
            j--;
        while (j > i)
        begin
            if (cur[j] != WORD_ZERO)
            begin
                for (t = 0; t < NUM_WORDS; t++)
                    top[t] = (t < j) ? cur[t] : WORD_ALL;
                add_part(cur, top, 1'b0, 1'b0);
                for (t = j; t < NUM_WORDS; t++)
                    cur[t] = WORD_ZERO;
            end
            cur[j-1] = cur[j-1] + 1;
            j--;
        end
        // max side, highest word first
        j = NUM_WORDS - 1;
        while (j > i && mx[j] == WORD_ALL)
            j--;
        while (i < j)
        begin
            if (cur[i] != mx[i])
            begin
                for (t = 0; t < NUM_WORDS; t++)
                    top[t] = (t <= i) ? mx[t] : WORD_ALL;
                top[i] = mx[i] - 1;
                add_part(cur, top, 1'b0, 1'b0);
                for (t = 0; t < NUM_WORDS; t++)
                    cur[t] = (t <= i) ? mx[t] : WORD_ZERO;
            end
            i++;
        end
        add_part(cur, mx, 1'b0, 1'b1);
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 5))
            0: return WORD_ZERO;
            1: return WORD_ALL;
            2: return 32'd1;
            3: return WORD_ALL - 1;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d parts outstanding", cycle_count,
                     expected_parts.size());
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && part_valid && !part_stall)
        begin
            if (expected_parts.size() == 0)
            begin
                $error("unexpected part item %p", part_out);
                errors++;
            end
            else
            begin
                want_part = expected_parts.pop_front();
                if (part_out.part_min_hi !== want_part.part_min_hi)
                begin
                    $error("part_min_hi: expected %h, got %h", want_part.part_min_hi,
                           part_out.part_min_hi);
                    errors++;
                end
                if (part_out.part_min_lo !== want_part.part_min_lo)
                begin
                    $error("part_min_lo: expected %h, got %h", want_part.part_min_lo,
                           part_out.part_min_lo);
                    errors++;
                end
                if (part_out.part_max_hi !== want_part.part_max_hi)
                begin
                    $error("part_max_hi: expected %h, got %h", want_part.part_max_hi,
                           part_out.part_max_hi);
                    errors++;
                end
                if (part_out.part_max_lo !== want_part.part_max_lo)
                begin
                    $error("part_max_lo: expected %h, got %h", want_part.part_max_lo,
                           part_out.part_max_lo);
                    errors++;
                end
                if (part_out.is_empty !== want_part.is_empty)
                begin
                    $error("is_empty: expected %h, got %h", want_part.is_empty,
                           part_out.is_empty);
                    errors++;
                end
                if (part_out.last_part !== want_part.last_part)
                begin
                    $error("last_part: expected %h, got %h", want_part.last_part,
                           part_out.last_part);
                    errors++;
                end
            end
            parts_checked++;
            stall_left = part_idle ? $urandom_range(0, 19) : 0;
        end
        if (rst_n && range_valid && !range_stall)
        begin
            split_range(range_in);
            ranges_sent++;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            part_stall <= 1'b1;
            stall_left--;
        end
        else
            part_stall <= 1'b0;
    end

    task automatic send_range(input addr_t lo, input addr_t hi);
        range_t r;
        int     gap;
        {r.range_min_hi, r.range_min_lo} = lo;
        {r.range_max_hi, r.range_max_lo} = hi;
        gap = send_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            range_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        range_valid <= 1'b1;
        range_in    <= r;
        @(posedge clk);
        while (range_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_parts_drained();
        range_valid <= 1'b0;
        while (expected_parts.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_special_cases();
        send_range({32'd0, 32'd0, 32'd0, 32'd2}, {32'd0, 32'd0, 32'd0, 32'd1});
        send_range({32'd1, 32'd0, 32'd0, 32'd0}, {32'd0, WORD_ALL, WORD_ALL, WORD_ALL});
        send_range('1, '0);
        send_range('0, '0);
        send_range('0, '1);
        send_range({32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 32'hf0f0_f0f0},
                   {32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 32'hf0f0_f0f0});
        send_range('1, '1);
        send_range({32'd0, 32'd0, 32'd0, 32'd1}, {32'd0, 32'd0, 32'd0, 32'd1});
        send_range('0, {32'd0, 32'd1, 32'd0, 32'd0});
        send_range('0, {32'd0, 32'd0, 32'd1, 32'd5});
        wait_parts_drained();
    endtask

    task automatic test_split_shapes();
        send_range({32'd1, 32'd1, 32'd1, 32'd1}, {32'd5, 32'd5, 32'd5, 32'd5});
        send_range({32'd7, 32'd7, 32'd7, 32'd3}, {32'd7, 32'd7, 32'd7, 32'd9});
        send_range({32'd7, 32'd7, 32'd2, WORD_ALL}, {32'd7, 32'd7, 32'd9, 32'd0});
        send_range({32'd3, 32'd0, 32'd0, 32'd0}, {32'd9, WORD_ALL, WORD_ALL, WORD_ALL});
        send_range({32'ha, 32'd0, 32'd0, 32'd1}, {32'hb, WORD_ALL, WORD_ALL, WORD_ALL});
    endtask

    task automatic test_min_carry();
        send_range({WORD_ALL - 1, WORD_ALL, WORD_ALL, WORD_ALL}, '1);
        send_range({32'd1, WORD_ALL, WORD_ALL, 32'd5}, {32'd3, 32'd2, 32'd1, 32'd0});
        send_range({32'd0, 32'd5, WORD_ALL, WORD_ALL}, {32'd0, 32'd9, 32'd0, 32'd0});
        send_range({32'd0, 32'd0, WORD_ALL, WORD_ALL}, {32'd0, 32'd1, 32'd0, 32'd0});
        wait_parts_drained();
    endtask

    task automatic test_random_ranges();
        int    phase;
        int    n;
        int    k;
        int    t;
        addr_t lo;
        addr_t hi;
        word_t w;
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle = (phase == 0 || phase == 2);
            part_idle = (phase == 0 || phase == 3);
            for (n = 0; n < 23; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    lo = {$urandom, $urandom, $urandom, $urandom};
                    hi = {$urandom, $urandom, $urandom, $urandom};
                    if ($urandom_range(0, 2) == 0)
                        hi = '0;
                end
                else
                begin
                    k = ($urandom_range(0, 7) == 0) ? NUM_WORDS : $urandom_range(0, 3);
                    for (t = 0; t < NUM_WORDS; t++)
                    begin
                        lo[t] = pick_word();
                        hi[t] = pick_word();
                        if (t < k)
                            hi[t] = lo[t];
                    end
                    if (k < NUM_WORDS)
                    begin
                        if (lo[k] > hi[k])
                        begin
                            w     = lo[k];
                            lo[k] = hi[k];
                            hi[k] = w;
                        end
                        else if (lo[k] == hi[k])
                        begin
                            if (hi[k] == WORD_ALL)
                                lo[k] = lo[k] - 1;
                            else
                                hi[k] = hi[k] + 1;
                        end
                    end
                end
                send_range(lo, hi);
            end
            wait_parts_drained();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        range_valid = 1'b0;
        range_in    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_special_cases();
        test_split_shapes();
        test_min_carry();
        test_random_ranges();
        wait_parts_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d range items: empty, any-address, single-address, carry",
                 ranges_sent);
        $display("and multi-part splits under mixed gaps and stalls, %0d parts compared",
                 parts_checked);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/irws_pkg.sv
hdl/ipv6_range_word_splitter.sv
verif/tb.sv
